FILE: src/bu2x_pkg.sv
// ----------------------------------------------------------------------------
// bu2x_pkg
// shared types, constants and pixel helpers for the 2x bilinear upscaler
// ----------------------------------------------------------------------------
package bu2x_pkg;

  // default depth of the line store (widest source row)
  localparam int MAX_WIDTH_DEFAULT = 512;

  // field widths
  localparam int PIX_W  = 32;
  localparam int CH_W   = 5;
  localparam int RGB_W  = 3 * CH_W;
  localparam int FW_W   = 10;
  localparam int FH_W   = 12;
  localparam int SH_W   = 5;
  localparam int CM_W   = 2;
  localparam int COL_W  = 9;
  localparam int ROW_W  = 12;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 12;

  localparam logic [CH_W-1:0] CHAN_MASK = 5'h1f;

  // register reset values
  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 10'd240;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd160;
  localparam logic [SH_W-1:0] RED_SHIFT_RESET    = 5'd10;
  localparam logic [SH_W-1:0] GREEN_SHIFT_RESET  = 5'd5;
  localparam logic [SH_W-1:0] BLUE_SHIFT_RESET   = 5'd0;

  // item kinds on the input channel
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // upper left rules
  typedef enum logic [CM_W-1:0] {
    CORNER_COPY = 2'd0,
    CORNER_PLUS = 2'd1,
    CORNER_ORIG = 2'd2
  } corner_t;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RED_SHIFT    = 3'd2,
    REG_GREEN_SHIFT  = 3'd3,
    REG_BLUE_SHIFT   = 3'd4,
    REG_CORNER_MODE  = 3'd5
  } reg_index_t;

  // internal pixel: red, green, blue from msb down
  typedef logic [RGB_W-1:0] rgb_t;

  // pixel format and corner rule, handed to the arithmetic
  typedef struct packed {
    logic [SH_W-1:0] red_shift;
    logic [SH_W-1:0] green_shift;
    logic [SH_W-1:0] blue_shift;
    logic [CM_W-1:0] corner_mode;
  } pix_cfg_t;

  // pull the three channels out of a packed pixel
  function automatic rgb_t unpack_pixel(input logic [PIX_W-1:0] px, input pix_cfg_t cfg);
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    r = (px >> cfg.red_shift) & PIX_W'(CHAN_MASK);
    g = (px >> cfg.green_shift) & PIX_W'(CHAN_MASK);
    b = (px >> cfg.blue_shift) & PIX_W'(CHAN_MASK);
    return {r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0]};
  endfunction

  // place three channels at their shifts, bits beyond the word dropped
  function automatic logic [PIX_W-1:0] pack_pixel(input logic [CH_W-1:0] r,
                                                   input logic [CH_W-1:0] g,
                                                   input logic [CH_W-1:0] b,
                                                   input pix_cfg_t cfg);
    return (PIX_W'(r) << cfg.red_shift) | (PIX_W'(g) << cfg.green_shift)
         | (PIX_W'(b) << cfg.blue_shift);
  endfunction

endpackage

FILE: src/bu2x_line_store.sv
// ----------------------------------------------------------------------------
// bu2x_line_store
// previous source row: one write port, two registered read ports
// ----------------------------------------------------------------------------
module bu2x_line_store #(
  parameter int DEPTH = bu2x_pkg::MAX_WIDTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr0,
  input  logic [AW-1:0]       rd_addr1,
  output bu2x_pkg::rgb_t      rd_data0,
  output bu2x_pkg::rgb_t      rd_data1,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  bu2x_pkg::rgb_t      wr_data
);
  import bu2x_pkg::*;

  rgb_t mem [DEPTH];

  // read returns the old contents when the same entry is written
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

FILE: src/bu2x_quad_calc.sv
// ----------------------------------------------------------------------------
// bu2x_quad_calc
// blends four source pixels into the packed 2x2 result quad
// ----------------------------------------------------------------------------
module bu2x_quad_calc (
  input  bu2x_pkg::pix_cfg_t         cfg,
  input  bu2x_pkg::rgb_t             pa,
  input  bu2x_pkg::rgb_t             pb,
  input  bu2x_pkg::rgb_t             pc,
  input  bu2x_pkg::rgb_t             pd,
  output logic [bu2x_pkg::PIX_W-1:0] ul,
  output logic [bu2x_pkg::PIX_W-1:0] ur,
  output logic [bu2x_pkg::PIX_W-1:0] ll,
  output logic [bu2x_pkg::PIX_W-1:0] lr
);
  import bu2x_pkg::*;

  logic [CH_W-1:0] ul_ch [3];
  logic [CH_W-1:0] ur_ch [3];
  logic [CH_W-1:0] ll_ch [3];
  logic [CH_W-1:0] lr_ch [3];

  // per channel: index 0 red, 1 green, 2 blue
  for (genvar i = 0; i < 3; i++) begin : g_chan
    logic [CH_W-1:0] va, vb, vc, vd;
    logic [CH_W:0]   s_ab, s_ac;
    logic [CH_W+1:0] s_abcd;
    logic [CH_W+2:0] five_a, s_plus, s_orig;

    assign va = pa[RGB_W-1-CH_W*i -: CH_W];
    assign vb = pb[RGB_W-1-CH_W*i -: CH_W];
    assign vc = pc[RGB_W-1-CH_W*i -: CH_W];
    assign vd = pd[RGB_W-1-CH_W*i -: CH_W];

    // neighbour averages
    assign s_ab   = (CH_W+1)'(va) + (CH_W+1)'(vb);
    assign s_ac   = (CH_W+1)'(va) + (CH_W+1)'(vc);
    assign s_abcd = (CH_W+2)'(s_ab) + (CH_W+2)'(vc) + (CH_W+2)'(vd);

    // weighted corner blends, both stay below 256
    assign five_a = {1'b0, va, 2'b00} + (CH_W+3)'(va);
    assign s_plus = five_a + (CH_W+3)'(vb) + (CH_W+3)'(vc);
    assign s_orig = five_a + {2'b00, vb, 1'b0} + (CH_W+3)'(vc);

    assign ur_ch[i] = s_ab[CH_W:1];
    assign ll_ch[i] = s_ac[CH_W:1];
    assign lr_ch[i] = s_abcd[CH_W+1:2];

    always_comb begin
      case (cfg.corner_mode)
        CORNER_PLUS: ul_ch[i] = s_plus[CH_W+2:3];
        CORNER_ORIG: ul_ch[i] = s_orig[CH_W+2:3];
        default:     ul_ch[i] = va;
      endcase
    end
  end

  // repack at the configured positions
  assign ul = pack_pixel(ul_ch[0], ul_ch[1], ul_ch[2], cfg);
  assign ur = pack_pixel(ur_ch[0], ur_ch[1], ur_ch[2], cfg);
  assign ll = pack_pixel(ll_ch[0], ll_ch[1], ll_ch[2], cfg);
  assign lr = pack_pixel(lr_ch[0], lr_ch[1], lr_ch[2], cfg);

endmodule

FILE: src/bilinear_2x_upscaler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_2x_upscaler_unit
// streaming 2x bilinear upscaler: source pixels in, 2x2 quads out
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_ready     mode, source_pixel
//  out      source     out_valid / out_ready   four packed pixels, quad_column,
//                                              quad_row, last_of_run, frame_done
//  cfg      sink       cfg_en (no wait)        cfg_addr, cfg_data
//
//  an item is taken every cycle while the output does not stall and each item gives
//  at most one quad; a pixel ending a row below the first in a frame wider than one
//  gives two quads and holds the input until its second is sent, as the single
//  output register passes one quad per cycle. items pass the quad stage, then the
//  output register. reset clears counters, handshake state and the configuration
//  registers; the line store needs no clearing pass and holds nothing until the
//  first row has been written. a stall on the output holds the quad stage and
//  then the input.
// ----------------------------------------------------------------------------
module bilinear_2x_upscaler_unit #(
  parameter int MAX_WIDTH = bu2x_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_en,
  input  logic [bu2x_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [bu2x_pkg::CFG_DW-1:0]  cfg_data,
  // source items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [bu2x_pkg::PIX_W-1:0]   source_pixel,
  // result items
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bu2x_pkg::PIX_W-1:0]   upper_left,
  output logic [bu2x_pkg::PIX_W-1:0]   upper_right,
  output logic [bu2x_pkg::PIX_W-1:0]   lower_left,
  output logic [bu2x_pkg::PIX_W-1:0]   lower_right,
  output logic [bu2x_pkg::COL_W-1:0]   quad_column,
  output logic [bu2x_pkg::ROW_W-1:0]   quad_row,
  output logic                         last_of_run,
  output logic                         frame_done
);
  import bu2x_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (AW + 1 > FW_W) ? AW + 1 : FW_W;

  // configuration registers
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  pix_cfg_t        pcfg;

  // frame position
  logic [AW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             draining;

  // decode of the current position
  logic [CMPW-1:0]  w_eff;
  logic [CMPW-1:0]  w_last;
  logic [FH_W-1:0]  h_last;
  logic             row_end;
  logic             frame_end;
  logic             accept;
  logic             act_drain;
  logic             act_pix;
  logic             quad_a_pix;
  logic             quad_b_pix;
  rgb_t             new_pix;

  // line store and pixel history
  rgb_t rd0;
  rgb_t rd1;
  rgb_t pix;
  rgb_t left_pix;
  rgb_t ul_pix;

  // quad stage
  logic             s1_valid;
  logic             s1_need_a;
  logic             s1_need_b;
  logic             s1_drain;
  logic             s1_dup;
  logic             s1_done;
  logic [AW-1:0]    s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_last;
  logic             emit;

  // quad operands and results
  rgb_t             qa, qb, qc, qd;
  rgb_t             drain_b;
  logic [AW-1:0]    q_col;
  logic [PIX_W-1:0] ul_q, ur_q, ll_q, lr_q;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= FRAME_WIDTH_RESET;
      frame_height      <= FRAME_HEIGHT_RESET;
      pcfg.red_shift    <= RED_SHIFT_RESET;
      pcfg.green_shift  <= GREEN_SHIFT_RESET;
      pcfg.blue_shift   <= BLUE_SHIFT_RESET;
      pcfg.corner_mode  <= CORNER_COPY;
    end else if (cfg_en) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width      <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height     <= cfg_data[FH_W-1:0];
        REG_RED_SHIFT:    pcfg.red_shift   <= cfg_data[SH_W-1:0];
        REG_GREEN_SHIFT:  pcfg.green_shift <= cfg_data[SH_W-1:0];
        REG_BLUE_SHIFT:   pcfg.blue_shift  <= cfg_data[SH_W-1:0];
        REG_CORNER_MODE:  pcfg.corner_mode <= cfg_data[CM_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size and end-of-row / end-of-frame tests
  always_comb begin
    if (frame_width == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(frame_width) > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = CMPW'(frame_width);
    end
    w_last    = w_eff - CMPW'(1);
    h_last    = (frame_height == '0) ? '0 : frame_height - FH_W'(1);
    row_end   = CMPW'(col) >= w_last;
    frame_end = row >= h_last;
  end

  // what the offered item does
  assign accept     = in_valid && in_ready;
  assign act_drain  = accept && (mode == MODE_DRAIN) && draining;
  assign act_pix    = accept && (mode == MODE_PIXEL) && !draining;
  assign quad_a_pix = (row != '0) && (col != '0);
  assign quad_b_pix = (row != '0) && row_end;
  assign new_pix    = unpack_pixel(source_pixel, pcfg);

  // frame position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      draining <= 1'b0;
    end else if (act_drain) begin
      if (row_end) begin
        col      <= '0;
        row      <= '0;
        draining <= 1'b0;
      end else begin
        col <= col + AW'(1);
      end
    end else if (act_pix) begin
      if (row_end) begin
        col <= '0;
        if (frame_end) begin
          draining <= 1'b1;
        end else begin
          row <= row + ROW_W'(1);
        end
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // previous row
  bu2x_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (act_drain || act_pix),
    .rd_addr0 (col),
    .rd_addr1 (col + AW'(1)),
    .rd_data0 (rd0),
    .rd_data1 (rd1),
    .wr_en    (act_pix),
    .wr_addr  (col),
    .wr_data  (new_pix)
  );

  // pixel history: this pixel, its left neighbour, the one above that
  always_ff @(posedge clk) begin
    if (act_pix) begin
      pix      <= new_pix;
      left_pix <= pix;
      ul_pix   <= rd0;
    end
  end

  // quad stage handshake
  assign s1_last  = !(s1_need_a && s1_need_b);
  assign emit     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || (emit && s1_last);

  // quad stage: which quads the held item still owes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_need_a <= 1'b0;
      s1_need_b <= 1'b0;
    end else begin
      if (emit) begin
        if (s1_last) begin
          s1_valid <= 1'b0;
        end else begin
          s1_need_a <= 1'b0;
        end
      end
      if (act_drain) begin
        s1_valid  <= 1'b1;
        s1_need_a <= 1'b1;
        s1_need_b <= 1'b0;
      end else if (act_pix) begin
        s1_valid  <= quad_a_pix || quad_b_pix;
        s1_need_a <= quad_a_pix;
        s1_need_b <= quad_b_pix;
      end
    end
  end

  // quad stage: position of the held item
  always_ff @(posedge clk) begin
    if (act_drain) begin
      s1_drain <= 1'b1;
      s1_dup   <= row_end;
      s1_done  <= row_end;
      s1_col   <= col;
      s1_row   <= row;
    end else if (act_pix) begin
      s1_drain <= 1'b0;
      s1_dup   <= 1'b0;
      s1_done  <= 1'b0;
      s1_col   <= col;
      s1_row   <= row - ROW_W'(1);
    end
  end

  // operand selection for the quad being sent
  assign drain_b = s1_dup ? rd0 : rd1;

  always_comb begin
    if (s1_drain) begin
      qa    = rd0;
      qb    = drain_b;
      qc    = rd0;
      qd    = drain_b;
      q_col = s1_col;
    end else if (s1_need_a) begin
      qa    = ul_pix;
      qb    = rd0;
      qc    = left_pix;
      qd    = pix;
      q_col = s1_col - AW'(1);
    end else begin
      qa    = rd0;
      qb    = rd0;
      qc    = pix;
      qd    = pix;
      q_col = s1_col;
    end
  end

  bu2x_quad_calc u_quad_calc (
    .cfg (pcfg),
    .pa  (qa),
    .pb  (qb),
    .pc  (qc),
    .pd  (qd),
    .ul  (ul_q),
    .ur  (ur_q),
    .ll  (ll_q),
    .lr  (lr_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      upper_left  <= ul_q;
      upper_right <= ur_q;
      lower_left  <= ll_q;
      lower_right <= lr_q;
      quad_column <= COL_W'(q_col);
      quad_row    <= s1_row;
      last_of_run <= s1_last;
      frame_done  <= s1_done;
    end
  end

endmodule

FILE: src/bu2x_checker.sv
// ----------------------------------------------------------------------------
// bu2x_checker
// port-level checks on the upscaler, bound to the top level
// ----------------------------------------------------------------------------
module bu2x_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bu2x_pkg::PIX_W-1:0]   upper_left,
  input logic [bu2x_pkg::COL_W-1:0]   quad_column,
  input logic [bu2x_pkg::ROW_W-1:0]   quad_row,
  input logic                         last_of_run,
  input logic                         frame_done
);
  import bu2x_pkg::*;

  // after reset nothing is pending and the input is open
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("upscaler not idle after reset");

  // the frame ends only on the last quad of an item
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_run)
    else $error("frame_done on a quad that is not last of its item");

  // the first quad of a row end is followed at once by the edge quad beside it
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=>
      out_valid && last_of_run && quad_row == $past(quad_row)
      && quad_column == COL_W'($past(quad_column) + COL_W'(1)))
    else $error("second quad of a row end missing or misplaced");

  // a stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(upper_left) && $stable(quad_column) && $stable(last_of_run))
    else $error("result item changed while stalled");

endmodule

bind bilinear_2x_upscaler_unit bu2x_checker u_bu2x_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .upper_left  (upper_left),
  .quad_column (quad_column),
  .quad_row    (quad_row),
  .last_of_run (last_of_run),
  .frame_done  (frame_done)
);

FILE: tb/sv/bilinear_2x_upscaler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_2x_upscaler_unit_test
// self-checking bench for the streaming 2x bilinear upscaler. a predictor
// follows the raster walk, the line store copy and the quad arithmetic, and
// queues the expected quads for every accepted item; a checker compares each
// quad leaving the block field by field. directed frames cover the reset
// format, degenerate and extreme frame sizes, mid-frame shrinking, ignored
// items and one long output hold-off; random frames follow with random formats,
// corner rules and noise, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module bilinear_2x_upscaler_unit_test;
  import bu2x_pkg::*;

  localparam int          CLK_PERIOD    = 20;
  localparam int          RESET_CYCLES  = 11;
  localparam int          LINE_DEPTH    = MAX_WIDTH_DEFAULT;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          RANDOM_ITEMS  = 320;
  localparam int          TALL_ROWS     = 100;
  localparam int          MAX_REPORTS   = 100;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // corner code outside the named rules, behaves as copy
  localparam logic [CM_W-1:0] CORNER_SPARE = 2'd3;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_ONE_IN_THREE,
    READY_MOSTLY
  } ready_style_t;

  typedef struct packed {
    logic [PIX_W-1:0] ul;
    logic [PIX_W-1:0] ur;
    logic [PIX_W-1:0] ll;
    logic [PIX_W-1:0] lr;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last_flag;
    logic             done_flag;
  } quad_t;

  // dut ports
  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_en       = 1'b0;
  logic [CFG_AW-1:0] cfg_addr     = '0;
  logic [CFG_DW-1:0] cfg_data     = '0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic              mode         = MODE_PIXEL;
  logic [PIX_W-1:0]  source_pixel = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [PIX_W-1:0]  upper_left;
  logic [PIX_W-1:0]  upper_right;
  logic [PIX_W-1:0]  lower_left;
  logic [PIX_W-1:0]  lower_right;
  logic [COL_W-1:0]  quad_column;
  logic [ROW_W-1:0]  quad_row;
  logic              last_of_run;
  logic              frame_done;

  // predictor copy of the configuration
  logic [FW_W-1:0] cfg_width  = FRAME_WIDTH_RESET;
  logic [FH_W-1:0] cfg_height = FRAME_HEIGHT_RESET;
  logic [SH_W-1:0] red_pos    = RED_SHIFT_RESET;
  logic [SH_W-1:0] green_pos  = GREEN_SHIFT_RESET;
  logic [SH_W-1:0] blue_pos   = BLUE_SHIFT_RESET;
  logic [CM_W-1:0] cfg_corner = CORNER_COPY;

  // predictor copy of the raster state
  logic [RGB_W-1:0] line_copy [LINE_DEPTH] = '{default: '0};
  logic [RGB_W-1:0] left_px      = '0;
  logic [RGB_W-1:0] corner_px    = '0;
  int unsigned      column_pos   = 0;
  int unsigned      row_pos      = 0;
  bit               draining_now = 1'b0;

  quad_t       pending_quads [$];
  int unsigned applied_items = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  bit          gaps_enabled  = 1'b1;
  bit          hold_request  = 1'b0;

  bilinear_2x_upscaler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_en       (cfg_en),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .source_pixel (source_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .upper_left   (upper_left),
    .upper_right  (upper_right),
    .lower_left   (lower_left),
    .lower_right  (lower_right),
    .quad_column  (quad_column),
    .quad_row     (quad_row),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done)
  );

  // clock
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // width and height as the block uses them
  function automatic int unsigned active_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > LINE_DEPTH) return LINE_DEPTH;
    return cfg_width;
  endfunction

  function automatic int unsigned active_height();
    return (cfg_height == 0) ? 1 : cfg_height;
  endfunction

  // source word to internal red, green, blue
  function automatic logic [RGB_W-1:0] split_pixel(input logic [PIX_W-1:0] px);
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    r = px >> red_pos;
    g = px >> green_pos;
    b = px >> blue_pos;
    return {r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0]};
  endfunction

  // channels back into a result word, overflow past bit 31 lost
  function automatic logic [PIX_W-1:0] merge_pixel(input logic [CH_W-1:0] r,
                                                   input logic [CH_W-1:0] g,
                                                   input logic [CH_W-1:0] b);
    return (PIX_W'(r) << red_pos) | (PIX_W'(g) << green_pos) | (PIX_W'(b) << blue_pos);
  endfunction

  // quad from pixel a, right neighbour b, below c, below right d
  function automatic quad_t blend_quad(input logic [RGB_W-1:0] a, input logic [RGB_W-1:0] b,
                                       input logic [RGB_W-1:0] c, input logic [RGB_W-1:0] d,
                                       input int unsigned col, input int unsigned row,
                                       input bit last_flag, input bit done_flag);
    int unsigned   va, vb, vc, vd;
    logic [CH_W-1:0] ul_c [3];
    logic [CH_W-1:0] ur_c [3];
    logic [CH_W-1:0] ll_c [3];
    logic [CH_W-1:0] lr_c [3];
    quad_t         q;
    for (int i = 0; i < 3; i++) begin
      va = (32'(a) >> (10 - 5 * i)) & 32'h1f;
      vb = (32'(b) >> (10 - 5 * i)) & 32'h1f;
      vc = (32'(c) >> (10 - 5 * i)) & 32'h1f;
      vd = (32'(d) >> (10 - 5 * i)) & 32'h1f;
      case (cfg_corner)
        CORNER_PLUS: ul_c[i] = 5'((5 * va + vb + vc) >> 3);
        CORNER_ORIG: ul_c[i] = 5'((5 * va + 2 * vb + vc) >> 3);
        default:     ul_c[i] = 5'(va);
      endcase
      ur_c[i] = 5'((va + vb) >> 1);
      ll_c[i] = 5'((va + vc) >> 1);
      lr_c[i] = 5'((va + vb + vc + vd) >> 2);
    end
    q.ul        = merge_pixel(ul_c[0], ul_c[1], ul_c[2]);
    q.ur        = merge_pixel(ur_c[0], ur_c[1], ur_c[2]);
    q.ll        = merge_pixel(ll_c[0], ll_c[1], ll_c[2]);
    q.lr        = merge_pixel(lr_c[0], lr_c[1], lr_c[2]);
    q.column    = COL_W'(col);
    q.row       = ROW_W'(row);
    q.last_flag = last_flag;
    q.done_flag = done_flag;
    return q;
  endfunction

  // advance the raster state by one item, queue its quads; 0 when ignored
  function automatic bit predict_quads(input logic item_mode, input logic [PIX_W-1:0] px);
    int unsigned      w, h, col;
    bit               row_end;
    logic [RGB_W-1:0] a, b, p, above;
    w       = active_width();
    h       = active_height();
    col     = column_pos;
    row_end = (col >= w - 1);
    // drain step replays the last row against itself
    if (item_mode == MODE_DRAIN) begin
      if (!draining_now) return 1'b0;
      a = line_copy[col];
      b = row_end ? a : line_copy[col + 1];
      pending_quads.push_back(blend_quad(a, b, a, b, col, row_pos, 1'b1, row_end));
      if (row_end) begin
        column_pos   = 0;
        row_pos      = 0;
        draining_now = 1'b0;
      end else begin
        column_pos = col + 1;
      end
      return 1'b1;
    end
    if (draining_now) return 1'b0;
    // source pixel closes the quad to its upper left, and the edge quad at row end
    p     = split_pixel(px);
    above = line_copy[col];
    if (row_pos > 0) begin
      if (col > 0)
        pending_quads.push_back(blend_quad(corner_px, above, left_px, p, col - 1, row_pos - 1,
                                           !row_end, 1'b0));
      if (row_end)
        pending_quads.push_back(blend_quad(above, above, p, p, col, row_pos - 1, 1'b1, 1'b0));
    end
    corner_px      = above;
    line_copy[col] = p;
    left_px        = p;
    if (row_end) begin
      column_pos = 0;
      if (row_pos >= h - 1) draining_now = 1'b1;
      else row_pos = row_pos + 1;
    end else begin
      column_pos = col + 1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string where, input string name,
                             input logic [PIX_W-1:0] got, input logic [PIX_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s %s: got %h want %h", where, name, got, want));
  endtask

  // compare every quad leaving the block with the oldest expectation
  always @(posedge clk) begin : quad_check
    quad_t want;
    string where;
    if (!rst && out_valid && out_ready) begin
      if (pending_quads.size() == 0) begin
        report_mismatch($sformatf("unexpected quad row %0d col %0d", quad_row, quad_column));
      end else begin
        want  = pending_quads.pop_front();
        where = $sformatf("row %0d col %0d", want.row, want.column);
        check_field(where, "upper_left", upper_left, want.ul);
        check_field(where, "upper_right", upper_right, want.ur);
        check_field(where, "lower_left", lower_left, want.ll);
        check_field(where, "lower_right", lower_right, want.lr);
        check_field(where, "quad_column", PIX_W'(quad_column), PIX_W'(want.column));
        check_field(where, "quad_row", PIX_W'(quad_row), PIX_W'(want.row));
        check_field(where, "last_of_run", PIX_W'(last_of_run), PIX_W'(want.last_flag));
        check_field(where, "frame_done", PIX_W'(frame_done), PIX_W'(want.done_flag));
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // stall styles in random stretches, plus a long hold-off on request
  initial begin : receiver
    ready_style_t style;
    int unsigned  style_left;
    int unsigned  phase;
    int unsigned  hold_left;
    bit           ready_next;
    style      = READY_ALWAYS;
    style_left = 0;
    phase      = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        style      = ready_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 150);
      end
      style_left--;
      phase++;
      case (style)
        READY_ALWAYS:       ready_next = 1'b1;
        READY_COIN:         ready_next = ($urandom_range(0, 1) == 1);
        READY_ONE_IN_THREE: ready_next = (phase % 3 == 0);
        default:            ready_next = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end
      out_ready <= ready_next;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- sender

  // offer one item in bursts with random gaps, predict once accepted
  task automatic send_source_item(input logic item_mode, input logic [PIX_W-1:0] px);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = gaps_enabled ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    mode         <= item_mode;
    source_pixel <= px;
    do @(posedge clk); while (!in_ready);
    if (predict_quads(item_mode, px)) applied_items++;
  endtask

  // stop offering and wait until every expected quad has come out
  task automatic wait_quads_settled();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_quads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_en   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH:  cfg_width  = value[FW_W-1:0];
      REG_FRAME_HEIGHT: cfg_height = value[FH_W-1:0];
      REG_RED_SHIFT:    red_pos    = value[SH_W-1:0];
      REG_GREEN_SHIFT:  green_pos  = value[SH_W-1:0];
      REG_BLUE_SHIFT:   blue_pos   = value[SH_W-1:0];
      REG_CORNER_MODE:  cfg_corner = value[CM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_en <= 1'b0;
  endtask

  task automatic write_format(input int unsigned r, input int unsigned g, input int unsigned b,
                              input logic [CM_W-1:0] corner);
    write_reg(REG_RED_SHIFT, CFG_DW'(r));
    write_reg(REG_GREEN_SHIFT, CFG_DW'(g));
    write_reg(REG_BLUE_SHIFT, CFG_DW'(b));
    write_reg(REG_CORNER_MODE, CFG_DW'(corner));
  endtask

  // one well-formed frame with random content, noise items at the given rate
  task automatic stream_frame(input int unsigned noise_pct);
    int unsigned w, h;
    w = active_width();
    h = active_height();
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(0, 99) < noise_pct) send_source_item(MODE_DRAIN, $urandom());
        send_source_item(MODE_PIXEL, $urandom());
      end
    end
    // stray pixels while draining are dropped
    if ($urandom_range(0, 99) < noise_pct) send_source_item(MODE_PIXEL, $urandom());
    for (int c = 0; c < w; c++) send_source_item(MODE_DRAIN, $urandom());
  endtask

  // ---------------------------------------------------------------- tests

  // reset pixel format and copy rule, ignored items, extreme pixel words
  task automatic test_reset_format();
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 2);
    send_source_item(MODE_DRAIN, 32'h1234_5678);
    send_source_item(MODE_PIXEL, 32'h0000_0000);
    send_source_item(MODE_PIXEL, 32'hffff_ffff);
    send_source_item(MODE_PIXEL, 32'h0000_7fff);
    send_source_item(MODE_PIXEL, 32'hffff_ffff);
    send_source_item(MODE_PIXEL, 32'h0000_0000);
    send_source_item(MODE_PIXEL, 32'h5555_aaaa);
    send_source_item(MODE_PIXEL, 32'hffff_ffff);
    send_source_item(MODE_DRAIN, 32'hffff_ffff);
    send_source_item(MODE_DRAIN, 32'h0000_0000);
    send_source_item(MODE_DRAIN, 32'haaaa_5555);
  endtask

  // zero width and height act as one, top shifts, spare corner code
  task automatic test_degenerate_sizes();
    wait_quads_settled();
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_format(31, 27, 29, CORNER_SPARE);
    send_source_item(MODE_PIXEL, 32'hf800_0001);
    send_source_item(MODE_DRAIN, 32'h0000_0000);
    send_source_item(MODE_DRAIN, 32'hffff_ffff);
  endtask

  // width shrunk inside the first row, height shrunk inside the second
  task automatic test_mid_frame_resize();
    wait_quads_settled();
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_format(0, 10, 20, CORNER_ORIG);
    send_source_item(MODE_PIXEL, 32'h01f0_7c1f);
    send_source_item(MODE_PIXEL, 32'h0210_8421);
    wait_quads_settled();
    write_reg(REG_FRAME_WIDTH, 2);
    send_source_item(MODE_PIXEL, 32'h03ff_ffff);
    send_source_item(MODE_PIXEL, 32'h0000_001f);
    wait_quads_settled();
    write_reg(REG_FRAME_HEIGHT, 1);
    send_source_item(MODE_PIXEL, 32'h000f_8000);
    send_source_item(MODE_DRAIN, 32'h0);
    send_source_item(MODE_DRAIN, 32'h0);
  endtask

  // widest row, clamped from an oversize width, and a tall narrow frame
  task automatic test_extreme_sizes();
    wait_quads_settled();
    write_reg(REG_FRAME_WIDTH, 1023);
    write_reg(REG_FRAME_HEIGHT, 1);
    write_format(27, 17, 5, CORNER_PLUS);
    stream_frame(0);
    wait_quads_settled();
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, TALL_ROWS);
    write_format(0, 0, 0, CORNER_ORIG);
    stream_frame(2);
  endtask

  // long output hold-off while items keep coming, then a full pause
  task automatic test_backpressure();
    wait_quads_settled();
    write_reg(REG_FRAME_WIDTH, 10);
    write_reg(REG_FRAME_HEIGHT, 6);
    write_format(10, 5, 0, CORNER_PLUS);
    gaps_enabled = 1'b0;
    hold_request = 1'b1;
    stream_frame(0);
    wait_quads_settled();
    gaps_enabled = 1'b1;
    stream_frame(5);
  endtask

  // random frames, formats and corner rules, mostly well formed
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned w, h;
    goal = applied_items + RANDOM_ITEMS;
    while (applied_items < goal) begin
      if ($urandom_range(0, 1) == 0) begin
        w = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        h = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        if ($urandom_range(0, 39) == 0) w = 0;
        if ($urandom_range(0, 39) == 0) h = 0;
        wait_quads_settled();
        write_reg(REG_FRAME_WIDTH, CFG_DW'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DW'(h));
        write_format($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                     CM_W'($urandom_range(0, 3)));
      end
      gaps_enabled = ($urandom_range(0, 3) != 0);
      stream_frame(($urandom_range(0, 2) == 0) ? 10 : 0);
    end
    gaps_enabled = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_format();
    test_degenerate_sizes();
    test_mid_frame_resize();
    test_extreme_sizes();
    test_backpressure();
    test_random_frames();
    wait_quads_settled();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
